/* rtl/fupd_pkg.sv */
package fupd_pkg;

    localparam int MAX_HELD_BREAKS_DEF = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int OPS_MAX = 4;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [3:0] {
        PH_P0, PH_P1, PH_P2, PH_P3, PH_P4, PH_P5, PH_P6,
        PH_SEEK, PH_PATH, PH_BAD
    } t_phase;

    typedef enum logic [1:0] {
        ESC_IDLE, ESC_PCT, ESC_DIGIT
    } t_esc;

    typedef enum logic [1:0] {
        ST_OK, ST_BAD_PREFIX, ST_NO_PATH
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
        logic [1:0] out_status;
    } t_out;

    // one unit of work for the back end: a path byte or the closing status
    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
        t_status    status;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qwr;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qrd;

    function automatic logic [7:0] prefix_char(input t_phase ph);
        logic [7:0] ch;
        case (ph)
            PH_P0:   ch = 8'h66; // f
            PH_P1:   ch = 8'h69; // i
            PH_P2:   ch = 8'h6C; // l
            PH_P3:   ch = 8'h65; // e
            PH_P4:   ch = 8'h3A; // :
            PH_P5:   ch = 8'h2F; // /
            PH_P6:   ch = 8'h2F; // /
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

endpackage

/* rtl/fupd_front.sv */
module fupd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  fupd_pkg::t_in  i_in_data,
    output logic           o_in_ready,
    input  logic           i_q_full,
    output fupd_pkg::t_qwr o_q_wr
);

    fupd_pkg::t_phase r_phase, n_phase, w_phase_mid;
    fupd_pkg::t_esc   r_esc, n_esc, w_esc_mid;
    logic [7:0]       r_digit, n_digit;

    fupd_pkg::t_op    r_ops [fupd_pkg::OPS_MAX];
    fupd_pkg::t_op    w_ops [fupd_pkg::OPS_MAX];
    logic [2:0]       w_nops;
    logic [2:0]       r_pend;
    logic [1:0]       r_idx;

    logic [7:0] w_c;
    logic       w_pct, w_hex, w_thru, w_accept;

    assign w_c      = i_in_data.in_byte;
    assign w_pct    = (w_c == fupd_pkg::CH_PCT);
    assign w_hex    = fupd_pkg::is_hex(w_c);
    assign w_thru   = (r_phase == fupd_pkg::PH_PATH)
                   || (r_phase == fupd_pkg::PH_SEEK && w_c == fupd_pkg::CH_SLASH);
    assign w_accept = i_in_valid && o_in_ready;

    // next state: phase and escape tracking
    always_comb begin
        w_phase_mid = r_phase;
        w_esc_mid   = r_esc;
        n_digit     = r_digit;
        if (r_phase < fupd_pkg::PH_SEEK) begin
            w_phase_mid = (w_c == fupd_pkg::prefix_char(r_phase))
                        ? fupd_pkg::t_phase'(r_phase + 4'd1) : fupd_pkg::PH_BAD;
        end else if (r_phase == fupd_pkg::PH_SEEK) begin
            if (w_c == fupd_pkg::CH_SLASH) begin
                w_phase_mid = fupd_pkg::PH_PATH;
            end
        end else if (r_phase != fupd_pkg::PH_PATH) begin
            w_phase_mid = fupd_pkg::PH_BAD;
        end
        if (w_thru) begin
            case (r_esc)
                fupd_pkg::ESC_IDLE: begin
                    w_esc_mid = w_pct ? fupd_pkg::ESC_PCT : fupd_pkg::ESC_IDLE;
                end
                fupd_pkg::ESC_PCT: begin
                    if (w_hex) begin
                        w_esc_mid = fupd_pkg::ESC_DIGIT;
                        n_digit   = w_c;
                    end else begin
                        w_esc_mid = w_pct ? fupd_pkg::ESC_PCT : fupd_pkg::ESC_IDLE;
                    end
                end
                fupd_pkg::ESC_DIGIT: begin
                    w_esc_mid = (!w_hex && w_pct) ? fupd_pkg::ESC_PCT : fupd_pkg::ESC_IDLE;
                end
                default: begin
                    w_esc_mid = fupd_pkg::ESC_IDLE;
                end
            endcase
        end
        n_phase = i_in_data.in_last ? fupd_pkg::PH_P0 : w_phase_mid;
        n_esc   = i_in_data.in_last ? fupd_pkg::ESC_IDLE : w_esc_mid;
    end

    // outputs: the list of ops this byte causes
    always_comb begin
        for (int k = 0; k < fupd_pkg::OPS_MAX; k++) begin
            w_ops[k] = '0;
        end
        w_nops = 3'd0;
        if (w_thru) begin
            case (r_esc)
                fupd_pkg::ESC_IDLE: begin
                    if (!w_pct) begin
                        w_ops[w_nops[1:0]].data = w_c;
                        w_nops = w_nops + 3'd1;
                    end
                end
                fupd_pkg::ESC_PCT: begin
                    if (!w_hex) begin
                        w_ops[w_nops[1:0]].data = fupd_pkg::CH_PCT;
                        w_nops = w_nops + 3'd1;
                        if (!w_pct) begin
                            w_ops[w_nops[1:0]].data = w_c;
                            w_nops = w_nops + 3'd1;
                        end
                    end
                end
                fupd_pkg::ESC_DIGIT: begin
                    if (w_hex) begin
                        w_ops[w_nops[1:0]].data = {fupd_pkg::hex_val(r_digit),
                                                   fupd_pkg::hex_val(w_c)};
                        w_nops = w_nops + 3'd1;
                    end else begin
                        w_ops[w_nops[1:0]].data = fupd_pkg::CH_PCT;
                        w_nops = w_nops + 3'd1;
                        w_ops[w_nops[1:0]].data = r_digit;
                        w_nops = w_nops + 3'd1;
                        if (!w_pct) begin
                            w_ops[w_nops[1:0]].data = w_c;
                            w_nops = w_nops + 3'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_in_data.in_last) begin
            if (w_phase_mid == fupd_pkg::PH_PATH) begin
                if (w_esc_mid != fupd_pkg::ESC_IDLE) begin
                    w_ops[w_nops[1:0]].data = fupd_pkg::CH_PCT;
                    w_nops = w_nops + 3'd1;
                end
                if (w_esc_mid == fupd_pkg::ESC_DIGIT) begin
                    w_ops[w_nops[1:0]].data = n_digit;
                    w_nops = w_nops + 3'd1;
                end
            end
            w_ops[w_nops[1:0]].is_end = 1'b1;
            if (w_phase_mid == fupd_pkg::PH_PATH) begin
                w_ops[w_nops[1:0]].status = fupd_pkg::ST_OK;
            end else if (w_phase_mid == fupd_pkg::PH_SEEK) begin
                w_ops[w_nops[1:0]].status = fupd_pkg::ST_NO_PATH;
            end else begin
                w_ops[w_nops[1:0]].status = fupd_pkg::ST_BAD_PREFIX;
            end
            w_nops = w_nops + 3'd1;
        end
    end

    // first op goes straight to the queue, the rest drain one a cycle while it is not full
    assign o_in_ready     = (r_pend == 3'd0) && !i_q_full;
    assign o_q_wr.valid   = (r_pend != 3'd0) ? !i_q_full : (w_accept && w_nops != 3'd0);
    assign o_q_wr.op      = (r_pend != 3'd0) ? r_ops[r_idx] : w_ops[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fupd_pkg::PH_P0;
            r_esc   <= fupd_pkg::ESC_IDLE;
            r_pend  <= 3'd0;
            r_idx   <= 2'd0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_pend  <= (w_nops != 3'd0) ? w_nops - 3'd1 : 3'd0;
            r_idx   <= 2'd1;
        end else if (r_pend != 3'd0 && !i_q_full) begin
            r_pend  <= r_pend - 3'd1;
            r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_digit <= n_digit;
            r_ops   <= w_ops;
        end
    end

endmodule

/* rtl/fupd_queue.sv */
module fupd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fupd_pkg::t_qwr i_wr,
    output logic           o_full,
    output fupd_pkg::t_qrd o_head,
    input  logic           i_pop
);

    localparam int AW = $clog2(fupd_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(fupd_pkg::QUEUE_DEPTH + 1);

    fupd_pkg::t_op r_mem [fupd_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign w_push = i_wr.valid && !o_full;
    assign w_pop  = i_pop && (r_cnt != '0);
    assign o_full = (r_cnt == CW'(fupd_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.op    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(fupd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(fupd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_wr.op;
        end
    end

endmodule

/* rtl/fupd_back.sv */
module fupd_back #(
    parameter int MAX_HELD_BREAKS = fupd_pkg::MAX_HELD_BREAKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fupd_pkg::t_qrd i_head,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fupd_pkg::t_out o_out_data
);

    localparam int CW = $clog2(MAX_HELD_BREAKS + 1);

    // held CR/LF run, oldest in bit 0 (1 = LF)
    logic [MAX_HELD_BREAKS-1:0] r_held, n_held;
    logic [CW-1:0]              r_hcnt, n_hcnt;
    logic                       r_ovalid;
    fupd_pkg::t_out             r_out, w_item;
    logic                       w_slot, w_emit, w_brk, w_lf;
    fupd_pkg::t_out             w_brk_item;

    assign w_slot = !r_ovalid || i_out_ready;
    assign w_brk  = (i_head.op.data == fupd_pkg::CH_CR) || (i_head.op.data == fupd_pkg::CH_LF);
    assign w_lf   = (i_head.op.data == fupd_pkg::CH_LF);

    always_comb begin
        w_brk_item            = '0;
        w_brk_item.out_byte   = r_held[0] ? fupd_pkg::CH_LF : fupd_pkg::CH_CR;
        w_brk_item.out_valid  = 1'b1;
    end

    always_comb begin
        n_held = r_held;
        n_hcnt = r_hcnt;
        o_pop  = 1'b0;
        w_emit = 1'b0;
        w_item = w_brk_item;
        if (i_head.valid && w_slot) begin
            if (i_head.op.is_end) begin
                // trailing breaks are dropped
                w_item            = '0;
                w_item.out_last   = 1'b1;
                w_item.out_status = i_head.op.status;
                w_emit = 1'b1;
                o_pop  = 1'b1;
                n_held = '0;
                n_hcnt = '0;
            end else if (w_brk) begin
                o_pop = 1'b1;
                if (r_hcnt == CW'(MAX_HELD_BREAKS)) begin
                    w_emit = 1'b1;
                    n_held = (r_held >> 1)
                           | (MAX_HELD_BREAKS'(w_lf) << (MAX_HELD_BREAKS - 1));
                end else begin
                    n_held = r_held | (MAX_HELD_BREAKS'(w_lf) << r_hcnt);
                    n_hcnt = r_hcnt + 1'b1;
                end
            end else if (r_hcnt != '0) begin
                w_emit = 1'b1;
                n_held = r_held >> 1;
                n_hcnt = r_hcnt - 1'b1;
            end else begin
                w_item           = '0;
                w_item.out_byte  = i_head.op.data;
                w_item.out_valid = 1'b1;
                w_emit = 1'b1;
                o_pop  = 1'b1;
                n_held = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_hcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_held <= n_held;
            r_hcnt <= n_hcnt;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_item;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

/* rtl/file_uri_path_decoder_unit.sv */
// Decodes the path of a "file://" URI, one byte per transfer.
// Input channel: i_in_valid / o_in_ready with i_in_data (byte, last flag).
// Output channel: o_out_valid / i_out_ready with o_out_data. Path bytes come
// with out_valid set; after the last input byte one closing transfer carries
// out_last and the status (ok, bad prefix, no path slash).
// The front end checks the prefix, skips the host and resolves %XX escapes;
// each input byte yields zero to four ops (path bytes or the closing status),
// written to a four-entry queue one per cycle while it is not full; a byte that
// yields several ops holds the input until all are written (ordinary bytes: one
// per cycle). The back end holds CR/LF runs and releases one held break per
// cycle, while the output accepts, ahead of the next plain byte; when the run
// is full, a further break releases the oldest held break at once. Every result
// passes through a queue entry and the registered output; a stalled receiver
// fills the queue and then holds o_in_ready low, with no loss. Synchronous reset
// clears phase, escape state, queue and held run; there is no clearing pass.
module file_uri_path_decoder_unit #(
    parameter int MAX_HELD_BREAKS = fupd_pkg::MAX_HELD_BREAKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fupd_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fupd_pkg::t_out o_out_data
);

    fupd_pkg::t_qwr q_wr;
    fupd_pkg::t_qrd q_head;
    logic           q_full, q_pop;

    fupd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr)
    );

    fupd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    fupd_back #(
        .MAX_HELD_BREAKS (MAX_HELD_BREAKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr.valid |-> !q_full)
        else $error("op written to a full queue");

    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head.valid)
        else $error("pop from an empty queue");

    a_status_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.out_last) |->
            (o_out_data.out_status == fupd_pkg::ST_OK && o_out_data.out_valid))
        else $error("path byte carries a status");

    a_last_has_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_last) |-> !o_out_data.out_valid)
        else $error("closing transfer marked as path byte");

endmodule
